/* rtl/tmsd_pkg.sv */
package tmsd_pkg;

  localparam int unsigned ADDR_BYTES_DEF = 4;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned MASK_W         = 10;

  // opcode bytes as they appear in the stream
  localparam logic [7:0] OPB_SET_BASE    = 8'h01;
  localparam logic [7:0] OPB_TAG_ADDR    = 8'h02;
  localparam logic [7:0] OPB_TAG_RANGE   = 8'h03;
  localparam logic [7:0] OPB_POLICY_A    = 8'h04;
  localparam logic [7:0] OPB_POLICY_B    = 8'h05;
  localparam logic [7:0] OPB_RANKED_A    = 8'h06;
  localparam logic [7:0] OPB_RANKED_B    = 8'h07;
  localparam logic [7:0] OPB_END_BLOCK   = 8'h08;
  localparam logic [7:0] OPB_WEAK_DECL   = 8'h09;
  localparam logic [7:0] OPB_FUNC_RANGE  = 8'h0a;

  typedef enum logic [3:0] {
    OP_NONE       = 4'h0,
    OP_SET_BASE   = 4'h1,
    OP_TAG_ADDR   = 4'h2,
    OP_TAG_RANGE  = 4'h3,
    OP_END_BLOCK  = 4'h8,
    OP_FUNC_RANGE = 4'ha
  } opcode_t;

  typedef enum logic [1:0] {
    ST_RANGE   = 2'd0,
    ST_POLICY  = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_NO_BASE = 2'd3
  } status_t;

  // finished record handed from the parser to the address stage
  typedef struct packed {
    status_t     status;
    logic [63:0] base;
    logic [63:0] start_off;
    logic [63:0] end_off;
    logic [7:0]  tag;
  } rec_t;

endpackage

/* rtl/tmsd_parser.sv */
module tmsd_parser #(
  parameter int unsigned ADDRESS_BYTES = tmsd_pkg::ADDR_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_fire,
  input  logic [7:0]                  stream_byte,
  input  logic                        stream_start,
  input  logic [tmsd_pkg::MASK_W-1:0] tag_mask,
  input  logic                        rec_take,
  output logic                        in_ready,
  output logic                        rec_valid,
  output tmsd_pkg::rec_t              rec
);
  import tmsd_pkg::*;

  localparam logic [CNT_W-1:0] LEN_SET_BASE   = CNT_W'(8);
  localparam logic [CNT_W-1:0] LEN_TAG_ADDR   = CNT_W'(ADDRESS_BYTES + 1);
  localparam logic [CNT_W-1:0] LEN_TAG_RANGE  = CNT_W'(2 * ADDRESS_BYTES + 1);
  localparam logic [CNT_W-1:0] LEN_END_BLOCK  = CNT_W'(ADDRESS_BYTES);
  localparam logic [CNT_W-1:0] LEN_FUNC_RANGE = CNT_W'(2 * ADDRESS_BYTES);

  opcode_t          cur_op, cur_op_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [63:0]      base, base_next;
  logic [63:0]      op1, op1_next;
  logic [63:0]      op2, op2_next;
  logic             halted, halted_next;
  logic             first_pend, first_pend_next;

  opcode_t          eff_op;
  logic [CNT_W-1:0] eff_cnt;
  logic [63:0]      eff_base, eff_op1, eff_op2;
  logic             eff_halted, eff_pend;
  logic [CNT_W-1:0] total;
  logic             done, err, tag_en;
  status_t          err_st;
  logic             fire_rec;
  rec_t             rec_next;

  assign in_ready = !rec_valid || rec_take;

  // tag codes 1..10 map onto mask bits 0..9
  assign tag_en = (stream_byte >= 8'd1) && (stream_byte <= 8'd10) &&
                  tag_mask[stream_byte[3:0] - 4'd1];

  always_comb begin
    // a new stream clears the parser before its first byte is looked at
    eff_op     = stream_start ? OP_NONE : cur_op;
    eff_cnt    = stream_start ? '0 : cnt;
    eff_base   = stream_start ? '0 : base;
    eff_op1    = stream_start ? '0 : op1;
    eff_op2    = stream_start ? '0 : op2;
    eff_halted = stream_start ? 1'b0 : halted;
    eff_pend   = stream_start ? 1'b1 : first_pend;

    cur_op_next     = eff_op;
    cnt_next        = eff_cnt;
    base_next       = eff_base;
    op1_next        = eff_op1;
    op2_next        = eff_op2;
    halted_next     = eff_halted;
    first_pend_next = eff_pend;

    err      = 1'b0;
    err_st   = ST_UNKNOWN;
    fire_rec = 1'b0;
    rec_next = '0;
    total    = '0;
    done     = 1'b0;

    if (!eff_halted) begin
      if (eff_op == OP_NONE) begin
        if (eff_pend) begin
          first_pend_next = 1'b0;
          if (stream_byte != OPB_SET_BASE) begin
            err    = 1'b1;
            err_st = ST_NO_BASE;
          end
        end
        if (!err) begin
          unique case (stream_byte) inside
            OPB_SET_BASE, OPB_TAG_ADDR, OPB_TAG_RANGE, OPB_END_BLOCK,
            OPB_FUNC_RANGE: begin
              cur_op_next = opcode_t'(stream_byte[3:0]);
              cnt_next    = '0;
              op1_next    = '0;
              op2_next    = '0;
            end
            OPB_POLICY_A, OPB_POLICY_B, OPB_RANKED_A, OPB_RANKED_B,
            OPB_WEAK_DECL: begin
              err    = 1'b1;
              err_st = ST_POLICY;
            end
            default: begin
              err    = 1'b1;
              err_st = ST_UNKNOWN;
            end
          endcase
        end
        if (err) begin
          halted_next     = 1'b1;
          cur_op_next     = OP_NONE;
          cnt_next        = '0;
          fire_rec        = 1'b1;
          rec_next.status = err_st;
        end
      end else begin
        // operand bytes are little-endian; each lane is written once
        for (int i = 0; i < 8; i++) begin
          if ((eff_op == OP_SET_BASE || i < ADDRESS_BYTES) &&
              eff_cnt == CNT_W'(i))
            op1_next[8*i +: 8] = stream_byte;
          if ((eff_op == OP_TAG_RANGE || eff_op == OP_FUNC_RANGE) &&
              i < ADDRESS_BYTES && eff_cnt == CNT_W'(ADDRESS_BYTES + i))
            op2_next[8*i +: 8] = stream_byte;
        end
        unique case (eff_op)
          OP_SET_BASE:   total = LEN_SET_BASE;
          OP_TAG_ADDR:   total = LEN_TAG_ADDR;
          OP_TAG_RANGE:  total = LEN_TAG_RANGE;
          OP_END_BLOCK:  total = LEN_END_BLOCK;
          OP_FUNC_RANGE: total = LEN_FUNC_RANGE;
          default:       total = '0;
        endcase
        done     = (eff_cnt + CNT_W'(1)) == total;
        cnt_next = eff_cnt + CNT_W'(1);
        if (done) begin
          cur_op_next = OP_NONE;
          cnt_next    = '0;
          // last byte of a tag record is the tag itself
          rec_next.status = ST_RANGE;
          rec_next.base   = eff_base;
          rec_next.tag    = stream_byte;
          unique case (eff_op)
            OP_SET_BASE: base_next = op1_next;
            OP_TAG_ADDR: begin
              fire_rec           = tag_en;
              rec_next.start_off = eff_op1;
              rec_next.end_off   = eff_op1 + 64'(ADDRESS_BYTES);
            end
            OP_TAG_RANGE: begin
              fire_rec           = tag_en;
              rec_next.start_off = eff_op1;
              rec_next.end_off   = eff_op2;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_op     <= OP_NONE;
      cnt        <= '0;
      base       <= '0;
      op1        <= '0;
      op2        <= '0;
      halted     <= 1'b0;
      first_pend <= 1'b1;
      rec_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        cur_op     <= cur_op_next;
        cnt        <= cnt_next;
        base       <= base_next;
        op1        <= op1_next;
        op2        <= op2_next;
        halted     <= halted_next;
        first_pend <= first_pend_next;
        rec_valid  <= fire_rec;
      end else if (rec_take) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire)
      rec <= rec_next;
  end

  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && fire_rec && rec_next.status != ST_RANGE) |=> halted)
    else $error("error word did not halt the parser");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (cur_op == OP_NONE) |-> (cnt == '0))
    else $error("operand count left over while waiting for opcode");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt < LEN_TAG_RANGE || cnt < LEN_SET_BASE)
    else $error("operand count ran past record length");

endmodule

/* rtl/tmsd_emitter.sv */
module tmsd_emitter (
  input  logic              clk,
  input  logic              rst,
  input  logic              rec_valid,
  input  tmsd_pkg::rec_t    rec,
  output logic              rec_take,
  output logic              out_valid,
  input  logic              out_ready,
  output tmsd_pkg::status_t status,
  output logic [63:0]       range_start,
  output logic [63:0]       range_end,
  output logic [7:0]        tag_code
);
  import tmsd_pkg::*;

  assign rec_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_take) begin
      out_valid <= rec_valid;
    end
  end

  // error records carry zero offsets and base, so these sums come out zero
  always_ff @(posedge clk) begin
    if (rec_take && rec_valid) begin
      status      <= rec.status;
      range_start <= rec.base + rec.start_off;
      range_end   <= rec.base + rec.end_off;
      tag_code    <= rec.tag;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_RANGE) |->
      (range_start == '0 && range_end == '0 && tag_code == '0))
    else $error("error word with nonzero fields");

  a_tag_legal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_RANGE) |-> (tag_code != '0 && tag_code <= 8'd10))
    else $error("range word with tag code outside enable range");

endmodule

/* rtl/tag_metadata_stream_decoder.sv */
// Channel  Handshake               Payload
// in       in_valid / in_ready     stream_byte[7:0], stream_start
// out      out_valid / out_ready   status[1:0], range_start[63:0], range_end[63:0],
//                                  tag_code[7:0]
// cfg      cfg_valid / cfg_ready   enabled_tag_mask[9:0]
//
// One byte word is taken per cycle while in_ready is high. The parser stage
// (opcode decode, operand shift-in, end-offset add) registers the record when
// the byte that completes it is accepted; the address stage (base add) registers
// the result word when it takes that record from the parser stage.
// rst is synchronous; it clears the parser, the tag mask and both valid flags.
// Backpressure on out stalls the address stage, then the parser stage, then
// in_ready; with out_ready held high the decoder never stalls.
module tag_metadata_stream_decoder #(
  parameter int unsigned ADDRESS_BYTES = tmsd_pkg::ADDR_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // stream byte input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  stream_byte,
  input  logic                        stream_start,
  // tag mask write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tmsd_pkg::MASK_W-1:0] enabled_tag_mask,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output tmsd_pkg::status_t           status,
  output logic [63:0]                 range_start,
  output logic [63:0]                 range_end,
  output logic [7:0]                  tag_code
);
  import tmsd_pkg::*;

  logic [MASK_W-1:0] tag_mask;
  logic              in_fire;
  logic              rec_valid;
  logic              rec_take;
  rec_t              rec;

  // the user must see that the mask is only written while the decoder is idle; not enforced, so always ready
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_mask <= '0;
    end else if (cfg_valid) begin
      tag_mask <= enabled_tag_mask;
    end
  end

  tmsd_parser #(
    .ADDRESS_BYTES (ADDRESS_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .stream_byte  (stream_byte),
    .stream_start (stream_start),
    .tag_mask     (tag_mask),
    .rec_take     (rec_take),
    .in_ready     (in_ready),
    .rec_valid    (rec_valid),
    .rec          (rec)
  );

  tmsd_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .rec_valid   (rec_valid),
    .rec         (rec),
    .rec_take    (rec_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .range_start (range_start),
    .range_end   (range_end),
    .tag_code    (tag_code)
  );

endmodule

/* sim/tag_range_checker.sv */
module tag_range_checker #(
  parameter int unsigned ADDR_BYTES = tmsd_pkg::ADDR_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [7:0]                  stream_byte,
  input  logic                        stream_start,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tmsd_pkg::MASK_W-1:0] enabled_tag_mask,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  tmsd_pkg::status_t           status,
  input  logic [63:0]                 range_start,
  input  logic [63:0]                 range_end,
  input  logic [7:0]                  tag_code,
  output int                          mismatches,
  output int                          outstanding,
  output int                          ranges_seen,
  output int                          reports_seen
);

  import tmsd_pkg::*;

  typedef struct {
    status_t     kind;
    logic [63:0] first_addr;
    logic [63:0] end_addr;
    logic [7:0]  tag;
  } range_word_t;

  range_word_t          due_words[$];
  logic [MASK_W-1:0]    tag_mask;
  opcode_t              cur_op;
  logic [CNT_W-1:0]     opnd_cnt;
  logic [63:0]          base_addr;
  logic [63:0]          opnd_lo;
  logic [63:0]          opnd_hi;
  logic                 halted;
  logic                 need_base;

  task automatic clear_parser();
    cur_op    = OP_NONE;
    opnd_cnt  = '0;
    base_addr = '0;
    opnd_lo   = '0;
    opnd_hi   = '0;
    halted    = 1'b0;
    need_base = 1'b1;
  endtask

  task automatic push_word(input status_t k, input logic [63:0] s, input logic [63:0] e,
                           input logic [7:0] t);
    range_word_t w;
    w.kind       = k;
    w.first_addr = s;
    w.end_addr   = e;
    w.tag        = t;
    due_words.push_back(w);
  endtask

  // error words halt the parser until the next stream start
  task automatic flag_error(input status_t k);
    halted   = 1'b1;
    cur_op   = OP_NONE;
    opnd_cnt = '0;
    push_word(k, '0, '0, '0);
  endtask

  function automatic bit tag_on(input logic [7:0] t);
    return (t >= 8'd1) && (t <= 8'd10) && tag_mask[t[3:0] - 4'd1];
  endfunction

  task automatic decode_stream_byte(input logic [7:0] b, input logic s);
    logic [CNT_W-1:0] rec_len;
    opcode_t          done_op;
    if (s) clear_parser();
    if (!halted) begin
      if (cur_op == OP_NONE) begin
        if (need_base && b != OPB_SET_BASE) begin
          need_base = 1'b0;
          flag_error(ST_NO_BASE);
        end else begin
          need_base = 1'b0;
          case (b)
            OPB_SET_BASE, OPB_TAG_ADDR, OPB_TAG_RANGE, OPB_END_BLOCK, OPB_FUNC_RANGE: begin
              cur_op   = opcode_t'(b[3:0]);
              opnd_cnt = '0;
              opnd_lo  = '0;
              opnd_hi  = '0;
            end
            OPB_POLICY_A, OPB_POLICY_B, OPB_RANKED_A, OPB_RANKED_B, OPB_WEAK_DECL:
              flag_error(ST_POLICY);
            default:
              flag_error(ST_UNKNOWN);
          endcase
        end
      end else begin
        case (cur_op)
          OP_SET_BASE:   rec_len = CNT_W'(8);
          OP_TAG_ADDR:   rec_len = CNT_W'(ADDR_BYTES + 1);
          OP_TAG_RANGE:  rec_len = CNT_W'(2 * ADDR_BYTES + 1);
          OP_END_BLOCK:  rec_len = CNT_W'(ADDR_BYTES);
          OP_FUNC_RANGE: rec_len = CNT_W'(2 * ADDR_BYTES);
          default:       rec_len = '0;
        endcase
        // little-endian operand shift-in
        if (cur_op == OP_SET_BASE) begin
          if (opnd_cnt < 8) opnd_lo[8*opnd_cnt +: 8] = b;
        end else if (opnd_cnt < ADDR_BYTES) begin
          opnd_lo[8*opnd_cnt +: 8] = b;
        end else if ((cur_op == OP_TAG_RANGE || cur_op == OP_FUNC_RANGE) &&
                     opnd_cnt < 2 * ADDR_BYTES) begin
          opnd_hi[8*(opnd_cnt - ADDR_BYTES) +: 8] = b;
        end
        opnd_cnt = opnd_cnt + 1'b1;
        if (opnd_cnt >= rec_len) begin
          done_op  = cur_op;
          cur_op   = OP_NONE;
          opnd_cnt = '0;
          case (done_op)
            OP_SET_BASE: base_addr = opnd_lo;
            OP_TAG_ADDR:
              if (tag_on(b))
                push_word(ST_RANGE, base_addr + opnd_lo, base_addr + opnd_lo + ADDR_BYTES, b);
            OP_TAG_RANGE:
              if (tag_on(b))
                push_word(ST_RANGE, base_addr + opnd_lo, base_addr + opnd_hi, b);
            default: ;
          endcase
        end
      end
    end
  endtask

  always @(posedge clk) begin
    range_word_t w;
    if (rst) begin
      clear_parser();
      tag_mask = '0;
      due_words.delete();
      mismatches   = 0;
      ranges_seen  = 0;
      reports_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) tag_mask = enabled_tag_mask;
      if (in_valid && in_ready) decode_stream_byte(stream_byte, stream_start);
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word: status %0d start %h end %h tag %0d",
                   $time, status, range_start, range_end, tag_code);
        end else begin
          w = due_words.pop_front();
          if (w.kind == ST_RANGE) ranges_seen++;
          else reports_seen++;
          if (status !== w.kind) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, w.kind, status);
          end
          if (range_start !== w.first_addr) begin
            mismatches++;
            $display("%0t: range_start mismatch: expected %h, actual %h",
                     $time, w.first_addr, range_start);
          end
          if (range_end !== w.end_addr) begin
            mismatches++;
            $display("%0t: range_end mismatch: expected %h, actual %h",
                     $time, w.end_addr, range_end);
          end
          if (tag_code !== w.tag) begin
            mismatches++;
            $display("%0t: tag_code mismatch: expected %0d, actual %0d", $time, w.tag, tag_code);
          end
        end
      end
    end
    outstanding = due_words.size();
  end

endmodule

/* sim/tb_tag_metadata_stream_decoder.sv */
module tb_tag_metadata_stream_decoder;

  import tmsd_pkg::*;

  localparam int unsigned AB = ADDR_BYTES_DEF;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        stream_byte;
  logic              stream_start;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MASK_W-1:0] enabled_tag_mask;
  logic              out_valid;
  logic              out_ready;
  status_t           status;
  logic [63:0]       range_start;
  logic [63:0]       range_end;
  logic [7:0]        tag_code;

  int mismatches;
  int outstanding;
  int ranges_seen;
  int reports_seen;

  int items_sent;     // bytes sent as live traffic, noise streams included
  int dropped_sent;   // bytes sent on purpose while halted
  int mask_writes;
  bit no_idle;        // both sides run without gaps while set

  // staged bytes of the next burst: {stream_start, stream_byte}
  logic [8:0] burst[$];

  tag_metadata_stream_decoder i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .stream_byte      (stream_byte),
    .stream_start     (stream_start),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .enabled_tag_mask (enabled_tag_mask),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .range_start      (range_start),
    .range_end        (range_end),
    .tag_code         (tag_code)
  );

  tag_range_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .stream_byte      (stream_byte),
    .stream_start     (stream_start),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .enabled_tag_mask (enabled_tag_mask),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .range_start      (range_start),
    .range_end        (range_end),
    .tag_code         (tag_code),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .ranges_seen      (ranges_seen),
    .reports_seen     (reports_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // result side: random backpressure, ~8% of cycles stalled
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 8);
  end

  // hard stop in case a handshake never completes
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // One word on the byte channel. Called and returns at a falling edge.
  // valid may drop only in a gap before the word, never while it waits.
  task automatic send_byte(input logic [7:0] b, input logic s, input bit live);
    while (!no_idle && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    stream_byte  <= b;
    stream_start <= s;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
    if (live) items_sent++;
    else dropped_sent++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic s);
    burst.push_back({s, b});
  endtask

  // little-endian operand, n bytes
  task automatic queue_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) queue_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic send_burst(input bit live);
    foreach (burst[i]) send_byte(burst[i][7:0], burst[i][8], live);
    burst.delete();
  endtask

  // Mask writes only with the decoder drained; the extra cycles add margin after
  // the last result word has left the two-stage pipe.
  task automatic write_mask(input logic [MASK_W-1:0] m);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid        <= 1'b1;
    enabled_tag_mask <= m;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    mask_writes++;
  endtask

  function automatic logic [63:0] rand_addr();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_base();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '1;
    if (r < 20) return '0;
    if (r < 35) return {32'hFFFF_FFFF, $urandom};
    return {$urandom, $urandom};
  endfunction

  // mostly codes 1..10; the rest can never emit
  function automatic logic [7:0] rand_tag();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 8'($urandom_range(10, 1));
    if (r < 90) return 8'd0;
    return 8'($urandom_range(255, 11));
  endfunction

  // Stage one record. how_ended: 0 record complete, 1 error opcode (decoder
  // halts), 2 record cut short (next stream start drops it).
  task automatic queue_record(output int how_ended);
    int         r;
    int         len;
    logic [7:0] op;
    logic [7:0] policy_ops[5];
    policy_ops = '{OPB_POLICY_A, OPB_POLICY_B, OPB_RANKED_A, OPB_RANKED_B, OPB_WEAK_DECL};
    how_ended = 0;
    r = $urandom_range(99);
    if (r < 35) begin
      queue_byte(OPB_TAG_ADDR, 1'b0);
      queue_le(rand_addr(), AB);
      queue_byte(rand_tag(), 1'b0);
    end else if (r < 65) begin
      queue_byte(OPB_TAG_RANGE, 1'b0);
      queue_le(rand_addr(), AB);
      queue_le(rand_addr(), AB);
      queue_byte(rand_tag(), 1'b0);
    end else if (r < 74) begin
      queue_byte(OPB_END_BLOCK, 1'b0);
      queue_le(rand_addr(), AB);
    end else if (r < 83) begin
      queue_byte(OPB_FUNC_RANGE, 1'b0);
      queue_le(rand_addr(), 2 * AB);
    end else if (r < 91) begin
      queue_byte(OPB_SET_BASE, 1'b0);
      queue_le(rand_base(), 8);
    end else if (r < 96) begin
      // policy-class or unknown opcode
      if ($urandom_range(1)) op = policy_ops[$urandom_range(4)];
      else if ($urandom_range(3) == 0) op = 8'h00;
      else op = 8'($urandom_range(255, 11));
      queue_byte(op, 1'b0);
      how_ended = 1;
    end else begin
      case ($urandom_range(4))
        0:       begin op = OPB_SET_BASE;   len = 8;          end
        1:       begin op = OPB_TAG_ADDR;   len = AB + 1;     end
        2:       begin op = OPB_TAG_RANGE;  len = 2 * AB + 1; end
        3:       begin op = OPB_END_BLOCK;  len = AB;         end
        default: begin op = OPB_FUNC_RANGE; len = 2 * AB;     end
      endcase
      queue_byte(op, 1'b0);
      queue_le(rand_addr(), $urandom_range(len - 1));
      how_ended = 2;
    end
  endtask

  // Mostly well-formed streams with random content; the rest is noise that
  // may or may not open with the set-base opcode.
  task automatic random_stream();
    int n;
    int how_ended;
    if ($urandom_range(99) < 80) begin
      queue_byte(OPB_SET_BASE, 1'b1);
      queue_le(rand_base(), 8);
      n = $urandom_range(12, 1);
      how_ended = 0;
      for (int i = 0; i < n && how_ended == 0; i++) queue_record(how_ended);
      send_burst(1'b1);
      // bytes after an error opcode are dropped until the next start
      if (how_ended == 1)
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0, 1'b0);
    end else begin
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++)
        queue_byte($urandom_range(1) ? 8'($urandom) : 8'($urandom_range(11)), i == 0);
      send_burst(1'b1);
    end
  endtask

  function automatic logic [MASK_W-1:0] phase_mask(input int phase);
    case (phase % 8)
      0:       return 10'h000;
      1:       return MASK_W'($urandom_range(1023));
      2:       return 10'h001;
      3:       return 10'h200;
      4:       return 10'h155;
      5:       return 10'h2AA;
      6:       return MASK_W'($urandom_range(1023));
      default: return 10'h3FF;
    endcase
  endfunction

  initial begin
    int phase;
    int next_switch;

    rst              = 1'b1;
    in_valid         = 1'b0;
    stream_byte      = '0;
    stream_start     = 1'b0;
    cfg_valid        = 1'b0;
    enabled_tag_mask = '0;
    no_idle          = 1'b0;
    items_sent       = 0;
    dropped_sent     = 0;
    mask_writes      = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_mask(10'h3FF);

    // --- directed part ---
    // first stream has no start flag: the first byte after reset opens it.
    // Base all ones, so every add below wraps at 64 bits.
    queue_byte(OPB_SET_BASE, 1'b0);
    queue_le('1, 8);
    // single address, highest tag code
    queue_byte(OPB_TAG_ADDR, 1'b0);
    queue_le(64'h1, AB);
    queue_byte(8'd10, 1'b0);
    // range record with near-all-ones and small operands, lowest tag code
    queue_byte(OPB_TAG_RANGE, 1'b0);
    queue_le(64'hFFFF_FFFE, AB);
    queue_le(64'h3, AB);
    queue_byte(8'd1, 1'b0);
    // tag code zero is never enabled
    queue_byte(OPB_TAG_ADDR, 1'b0);
    queue_le('0, AB);
    queue_byte(8'd0, 1'b0);
    // policy opcode halts the stream
    queue_byte(OPB_POLICY_A, 1'b0);
    send_burst(1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);
    // new stream not led by set-base
    queue_byte(OPB_TAG_RANGE, 1'b1);
    // new stream, zero base, then an unknown opcode
    queue_byte(OPB_SET_BASE, 1'b1);
    queue_le('0, 8);
    queue_byte(8'hFF, 1'b0);
    send_burst(1'b1);

    // --- random part, one tag mask per phase ---
    phase       = 0;
    next_switch = items_sent + 300;
    while (items_sent < 1900) begin
      if (items_sent >= next_switch) begin
        write_mask(phase_mask(phase));
        phase++;
        next_switch = items_sent + 300;
      end
      no_idle = (items_sent >= 700) && (items_sent < 1000);
      random_stream();
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d stream bytes plus %0d dropped while halted, under %0d tag mask settings.",
             items_sent, dropped_sent, mask_writes);
    $display("Checked %0d tagged ranges and %0d error reports; %0d mismatches.",
             ranges_seen, reports_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
